>>> design/v810_pkg.sv
// Package with operation codes, transaction types and shared helpers of the integer execute unit.
package v810_pkg;

	typedef enum logic [4:0] {
		OP_MOV   = 5'd0,
		OP_ADD   = 5'd1,
		OP_SUB   = 5'd2,
		OP_CMP   = 5'd3,
		OP_SHL   = 5'd4,
		OP_SHR   = 5'd5,
		OP_SAR   = 5'd6,
		OP_MUL   = 5'd7,
		OP_MULU  = 5'd8,
		OP_DIV   = 5'd9,
		OP_DIVU  = 5'd10,
		OP_OR    = 5'd11,
		OP_AND   = 5'd12,
		OP_XOR   = 5'd13,
		OP_NOT   = 5'd14,
		OP_SETF  = 5'd15,
		OP_BCOND = 5'd16,
		OP_ADDNF = 5'd17,
		OP_MPYHW = 5'd18,
		OP_XB    = 5'd19,
		OP_XH    = 5'd20
	} op_t;

	localparam logic [31:0] SIGN_MIN = 32'h8000_0000;
	localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

	typedef struct packed {
		logic [4:0]  operation;
		logic [31:0] first_operand;
		logic [31:0] second_operand;
		logic [3:0]  condition_code;
	} in_t;

	typedef struct packed {
		logic [31:0] result;
		logic [31:0] high_result;
		logic        write_result;
		logic        write_high;
		logic        condition_true;
		logic        flag_zero;
		logic        flag_sign;
		logic        flag_overflow;
		logic        flag_carry;
		logic        divide_by_zero;
	} out_t;

	// Operation class decided by the front end.
	typedef enum logic [1:0] {
		CL_SIMPLE = 2'd0,
		CL_MUL    = 2'd1,
		CL_DIV    = 2'd2
	} class_t;

	// Decoded entry that travels through the queue.
	typedef struct packed {
		in_t    item;
		class_t cls;
	} dec_t;

	// Flags: bit0 Z, bit1 S, bit2 OV, bit3 CY.
	function automatic logic cond_holds(logic [3:0] cc, logic [3:0] f);
		logic v;
		unique case (cc[2:0])
			3'd0: v = f[2];
			3'd1: v = f[3];
			3'd2: v = f[0];
			3'd3: v = f[3] | f[0];
			3'd4: v = f[1];
			3'd5: v = 1'b1;
			3'd6: v = f[1] ^ f[2];
			3'd7: v = (f[1] ^ f[2]) | f[0];
			default: v = 1'b0;
		endcase
		return cc[3] ? ~v : v;
	endfunction

endpackage

>>> design/v810_front.sv
// Front end: accepts transactions, classifies them and keeps a two-entry queue.
module v810_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  v810_pkg::in_t   in_data,
	output logic            q_valid,
	input  logic            q_ready,
	output v810_pkg::dec_t  q_data
);
	import v810_pkg::*;

	dec_t       mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	class_t     cls;
	logic       push, pop;

	always_comb begin
		unique case (in_data.operation)
			OP_MUL, OP_MULU: cls = CL_MUL;
			OP_DIV, OP_DIVU: cls = CL_DIV;
			default:         cls = CL_SIMPLE;
		endcase
	end

	assign in_ready = (count_q != 2'd2);
	assign push     = in_valid & in_ready;
	assign q_valid  = (count_q != 2'd0);
	assign pop      = q_valid & q_ready;
	assign q_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{item: in_data, cls: cls};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2) else $error("queue count overrun");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == 2'd2 |-> !push) else $error("push into full queue");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != 2'd0) else $error("pop from empty queue");

endmodule

>>> design/v810_muldiv.sv
// Iterative unit: multiply by shift-add and divide by restoring steps, one bit per cycle.
module v810_muldiv (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        is_div,
	input  logic [31:0] opa,
	input  logic [31:0] opb,
	output logic        done,
	output logic [31:0] lo,
	output logic [31:0] hi
);
	logic [5:0]  cnt_q;
	logic        busy_q, div_q;
	logic [63:0] acc_q;
	logic [31:0] b_q;
	logic [32:0] diff;
	logic [32:0] psum;

	// Division: acc holds remainder:quotient. Multiply: acc holds partial:multiplier.
	assign diff = {acc_q[63:31]} - {1'b0, b_q};
	assign psum = {1'b0, acc_q[63:32]} + (acc_q[0] ? {1'b0, b_q} : 33'd0);
	assign done = busy_q & (cnt_q == 6'd0);
	assign lo   = div_q ? acc_q[31:0] : acc_q[31:0];
	assign hi   = acc_q[63:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 6'd0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'd32;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= {32'd0, opa};
			b_q   <= opb;
			div_q <= is_div;
		end else if (busy_q && cnt_q != 6'd0) begin
			if (div_q) begin
				if (!diff[32]) acc_q <= {diff[31:0], acc_q[30:0], 1'b1};
				else           acc_q <= {acc_q[62:0], 1'b0};
			end else begin
				acc_q <= {psum, acc_q[31:1]};
			end
		end
	end

endmodule

>>> design/v810_back.sv
// Back end: executes queued operations, keeps the flags and holds the output register.
module v810_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	output logic            q_ready,
	input  v810_pkg::dec_t  q_data,
	output logic            out_valid,
	input  logic            out_ready,
	output v810_pkg::out_t  out_data
);
	import v810_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t      state_q;
	logic [3:0]  flags_q;
	out_t        out_q;
	logic        ovalid_q;
	in_t         cur_q;
	logic        na_q, nb_q, sdiv_q;
	logic        slot_free;

	in_t         it;
	logic [31:0] a, b, res, hi;
	logic [3:0]  f;
	logic        wr, wh, dz;
	logic [32:0] sum, dif;
	logic [4:0]  c;
	logic [31:0] mhw;
	logic [63:0] shl_w, shr_w;
	logic        take, start_md, md_done, pop_simple;
	logic [31:0] ua, ub, md_lo, md_hi;
	logic [31:0] p_lo, p_hi, q_lo, q_hi, ext;
	logic [31:0] md_res_lo, md_res_hi;
	out_t        simple_out, md_out;
	logic [3:0]  f_md;

	assign slot_free = !ovalid_q || out_ready;
	assign out_valid = ovalid_q;
	assign out_data  = out_q;

	assign it = q_data.item;
	assign a  = it.first_operand;
	assign b  = it.second_operand;
	assign c  = b[4:0];
	assign sum = {1'b0, a} + {1'b0, b};
	assign dif = {1'b0, a} - {1'b0, b};
	assign mhw = {{15{b[16]}}, b[16:0]};
	assign shl_w = {32'd0, a} << c;
	assign shr_w = (it.operation == OP_SAR) ? $unsigned($signed({a, 32'd0}) >>> c)
		: ({a, 32'd0} >> c);

	// Simple operations are computed combinationally from the queue head.
	always_comb begin
		res = 32'd0; hi = 32'd0; wr = 1'b0; wh = 1'b0; dz = 1'b0; f = flags_q;
		unique case (it.operation)
			OP_MOV: begin res = b; wr = 1'b1; end
			OP_ADD: begin
				res = sum[31:0]; wr = 1'b1;
				f = {sum[32], (a[31] ~^ b[31]) & (a[31] ^ res[31]), res[31], res == 32'd0};
			end
			OP_SUB, OP_CMP: begin
				f = {dif[32], (a[31] ^ b[31]) & (a[31] ^ dif[31]), dif[31], dif[31:0] == 32'd0};
				if (it.operation == OP_SUB) begin res = dif[31:0]; wr = 1'b1; end
			end
			OP_SHL: begin
				res = shl_w[31:0]; wr = 1'b1;
				f = {(c != 5'd0) & shl_w[32], 1'b0, res[31], res == 32'd0};
			end
			OP_SHR, OP_SAR: begin
				res = shr_w[63:32]; wr = 1'b1;
				f = {(c != 5'd0) & shr_w[31], 1'b0, res[31], res == 32'd0};
			end
			OP_OR, OP_AND, OP_XOR, OP_NOT: begin
				unique case (it.operation)
					OP_OR:   res = a | b;
					OP_AND:  res = a & b;
					OP_XOR:  res = a ^ b;
					default: res = ~b;
				endcase
				wr = 1'b1;
				f = {flags_q[3], 1'b0, res[31], res == 32'd0};
			end
			OP_SETF:  begin res = {31'd0, cond_holds(it.condition_code, flags_q)}; wr = 1'b1; end
			OP_ADDNF: begin res = sum[31:0]; wr = 1'b1; end
			OP_MPYHW: begin res = 32'(a * mhw); wr = 1'b1; end
			OP_XB:    begin res = {a[31:16], a[7:0], a[15:8]}; wr = 1'b1; end
			OP_XH:    begin res = {a[15:0], a[31:16]}; wr = 1'b1; end
			OP_DIV, OP_DIVU: begin
				dz = (b == 32'd0);
			end
			default: ;
		endcase
		simple_out = '{result: res, high_result: hi, write_result: wr, write_high: wh,
			condition_true: cond_holds(it.condition_code, f), flag_zero: f[0],
			flag_sign: f[1], flag_overflow: f[2], flag_carry: f[3], divide_by_zero: dz};
	end

	// Multiply and divide go to the iterative unit on magnitudes (or raw for mulu/divu).
	logic sgn, zero_div, div_ovf;
	assign sgn      = (it.operation == OP_MUL) || (it.operation == OP_DIV);
	assign zero_div = (q_data.cls == CL_DIV) && (b == 32'd0);
	assign div_ovf  = (it.operation == OP_DIV) && (a == SIGN_MIN) && (b == ALL_ONES);
	assign ua = (sgn && a[31]) ? 32'd0 - a : a;
	assign ub = (sgn && b[31]) ? 32'd0 - b : b;

	// A multiply or divide leaves the queue when the iterative unit starts; its
	// operands and condition code are kept in cur_q until the result is written.
	assign take       = (state_q == ST_IDLE) && q_valid && slot_free;
	assign start_md   = (state_q == ST_IDLE) && q_valid && (q_data.cls != CL_SIMPLE)
		&& !zero_div && !div_ovf;
	assign pop_simple = take && !start_md;
	assign q_ready    = pop_simple || start_md;

	v810_muldiv u_md (
		.clk(clk), .arst_n(arst_n), .start(start_md),
		.is_div(q_data.cls == CL_DIV), .opa(ua), .opb(ub),
		.done(md_done), .lo(md_lo), .hi(md_hi)
	);

	// Sign correction of the unsigned result, on the registered operand signs.
	always_comb begin
		{p_hi, p_lo} = (na_q ^ nb_q) ? 64'd0 - {md_hi, md_lo} : {md_hi, md_lo};
		q_lo = (na_q ^ nb_q) ? 32'd0 - md_lo : md_lo;
		q_hi = na_q ? 32'd0 - md_hi : md_hi;
		ext = 32'd0;
		if (sdiv_q) begin
			md_res_lo = q_lo; md_res_hi = q_hi;
			f_md = {flags_q[3], 1'b0, q_lo[31], q_lo == 32'd0};
		end else begin
			md_res_lo = p_lo; md_res_hi = p_hi;
			ext = (cur_q.operation == OP_MUL && p_lo[31]) ? ALL_ONES : 32'd0;
			f_md = {flags_q[3], p_hi != ext, p_lo[31], p_lo == 32'd0};
		end
		md_out = '{result: md_res_lo, high_result: md_res_hi, write_result: 1'b1,
			write_high: 1'b1,
			condition_true: cond_holds(cur_q.condition_code, f_md), flag_zero: f_md[0],
			flag_sign: f_md[1], flag_overflow: f_md[2], flag_carry: f_md[3],
			divide_by_zero: 1'b0};
	end

	// Result of the signed divide overflow case, which bypasses the iterative unit.
	out_t ovf_out;
	assign ovf_out = '{result: SIGN_MIN, high_result: 32'd0, write_result: 1'b1,
		write_high: 1'b1,
		condition_true: cond_holds(it.condition_code, {flags_q[3], 3'b110}),
		flag_zero: 1'b0, flag_sign: 1'b1, flag_overflow: 1'b1, flag_carry: flags_q[3],
		divide_by_zero: 1'b0};

	always_ff @(posedge clk) begin
		if (start_md) begin
			cur_q  <= it;
			na_q   <= sgn & a[31];
			nb_q   <= sgn & b[31];
			sdiv_q <= (q_data.cls == CL_DIV);
		end
		if (pop_simple) begin
			out_q <= div_ovf ? ovf_out : simple_out;
		end else if (state_q == ST_FIN && slot_free) begin
			out_q <= md_out;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			flags_q  <= 4'd0;
			ovalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start_md) state_q <= ST_RUN;
					if (pop_simple) begin
						flags_q  <= div_ovf ? {flags_q[3], 3'b110} :
							{simple_out.flag_carry, simple_out.flag_overflow,
							 simple_out.flag_sign, simple_out.flag_zero};
						ovalid_q <= 1'b1;
					end else if (out_ready) begin
						ovalid_q <= 1'b0;
					end
				end
				ST_RUN: begin
					if (out_ready) ovalid_q <= 1'b0;
					if (md_done) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (slot_free) begin
						flags_q  <= f_md;
						ovalid_q <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// While the iterative unit is busy the queue head waits for the next turn.
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("state not one-hot");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data)) else $error("output changed in stall");
	a_run_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !q_ready) else $error("queue popped while unit busy");

endmodule

>>> design/v810_integer_execute_unit.sv
// Top level of the V810-style integer execute unit: front queue, back execute and output.
//
// The block takes one transaction per operation on the input channel (in_valid,
// in_ready, in_data) and returns exactly one result transaction per operation on
// the output channel (out_valid, out_ready, out_data), in order.
// The front end classifies each operation and stores it in a two-entry queue, so
// new transactions are taken while the back end is busy or stalled.
// Simple operations pass from the queue register to the output register of the
// execute stage, and the back end can retire one per cycle while the output is
// not stalled. Multiply and divide operations run on a one-bit-per-cycle shift-add
// or restoring-divide unit, which occupies the back end and sets the throughput
// for those operations. A zero divisor or the signed overflow case of divide
// completes like a simple operation, without the iterative unit.
// Reset clears the queue, the condition flags and the output valid flag.
// When the receiver stalls, the result is held in the output register, the back
// end waits, and the queue fills; in_ready falls once both entries are taken.
module v810_integer_execute_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  v810_pkg::in_t   in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output v810_pkg::out_t  out_data
);
	import v810_pkg::*;

	logic q_valid, q_ready;
	dec_t q_data;

	v810_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
	);

	// The back end pops a multiply or divide from the queue when it starts it.
	v810_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

endmodule
